// ===== hdl/dre_pkg.sv =====
// shared constants, codes and beat types for the deque engine
// no dependencies
`timescale 1ns / 1ps

package dre_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 16;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ELEM_W     = 16;

  localparam logic [1:0] MODE_PUSH    = 2'd0;
  localparam logic [1:0] MODE_REVERSE = 2'd1;
  localparam logic [1:0] MODE_DELETE  = 2'd2;
  localparam logic [1:0] MODE_DRAIN   = 2'd3;

  localparam logic [1:0] ST_ELEMENT   = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ELEM_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ELEM_W-1:0] element;
    logic              last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic rev;
    logic del;
    logic stat_emit;
    logic rd_step;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic underflow;
    logic overflow;
    logic empty;
    logic last_idx;
  } stat_t;

  // physical position of head plus offset, offset at most DEPTH-1
  function automatic addr_t ring_pos(addr_t head, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

endpackage

// ===== hdl/dre_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/dre_ctrl.sv =====
// command decoder and drain sequencer for the deque engine
// depends on dre_pkg
`timescale 1ns / 1ps

module dre_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    mode,
  input  dre_pkg::stat_t stat,
  output dre_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (mode)
            dre_pkg::MODE_PUSH:    cmd.push = !stat.underflow;
            dre_pkg::MODE_REVERSE: cmd.rev  = !stat.underflow;
            dre_pkg::MODE_DELETE:  cmd.del  = !stat.underflow;
            dre_pkg::MODE_DRAIN: begin
              if (stat.underflow || stat.overflow || stat.empty) begin
                cmd.stat_emit = 1'b1;
                cmd.clear     = 1'b1;
              end else begin
                state_nxt = S_DRAIN;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      S_DRAIN: begin
        cmd.rd_step = 1'b1;
        if (stat.last_idx) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == S_DRAIN);

endmodule

// ===== hdl/dre_dp.sv =====
// deque datapath: ring pointers, flags, element store and result register
// depends on dre_pkg and dre_ram
`timescale 1ns / 1ps

module dre_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dre_pkg::cmd_t              cmd,
  input  logic [dre_pkg::ELEM_W-1:0] value,
  output dre_pkg::stat_t             stat,
  output logic                       out_strobe,
  output dre_pkg::out_t              out_data
);

  dre_pkg::addr_t head_r, head_nxt;
  dre_pkg::cnt_t  count_r, count_nxt;
  dre_pkg::addr_t idx_r, idx_nxt;
  logic           rev_r, rev_nxt;
  logic           unf_r, unf_nxt;
  logic           ovf_r, ovf_nxt;
  logic           pend_r;
  logic           pend_last_r;
  logic           stat_vld_r;
  logic [1:0]     stat_code_r;

  logic           full;
  logic           we;
  dre_pkg::addr_t waddr;
  dre_pkg::addr_t raddr;
  dre_pkg::cnt_t  rd_off;
  dre_pkg::data_t rdata;

  assign full   = (count_r == dre_pkg::CNT_W'(dre_pkg::DEPTH));
  assign we     = cmd.push && !full;
  assign waddr  = dre_pkg::ring_pos(head_r, count_r);
  assign rd_off = rev_r ? (count_r - dre_pkg::CNT_W'(1) - dre_pkg::CNT_W'(idx_r))
                        : dre_pkg::CNT_W'(idx_r);
  assign raddr  = dre_pkg::ring_pos(head_r, rd_off);

  assign stat.underflow = unf_r;
  assign stat.overflow  = ovf_r;
  assign stat.empty     = (count_r == '0);
  assign stat.last_idx  = (dre_pkg::CNT_W'(idx_r) + dre_pkg::CNT_W'(1) == count_r);

  dre_ram #(
    .WIDTH (dre_pkg::DATA_WIDTH),
    .DEPTH (dre_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (dre_pkg::data_t'(value)),
    .re    (cmd.rd_step),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    rev_nxt   = rev_r;
    unf_nxt   = unf_r;
    ovf_nxt   = ovf_r;
    if (cmd.push) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + dre_pkg::CNT_W'(1);
      end
    end
    if (cmd.rev) begin
      rev_nxt = !rev_r;
    end
    if (cmd.del) begin
      if (count_r == '0) begin
        unf_nxt = 1'b1;
      end else begin
        if (!rev_r) begin
          head_nxt = dre_pkg::ring_pos(head_r, dre_pkg::CNT_W'(1));
        end
        count_nxt = count_r - dre_pkg::CNT_W'(1);
      end
    end
    if (cmd.rd_step) begin
      idx_nxt = idx_r + dre_pkg::ADDR_W'(1);
    end
    if (cmd.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
      idx_nxt   = '0;
      rev_nxt   = 1'b0;
      unf_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      idx_r      <= '0;
      rev_r      <= 1'b0;
      unf_r      <= 1'b0;
      ovf_r      <= 1'b0;
      pend_r     <= 1'b0;
      stat_vld_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      idx_r      <= idx_nxt;
      rev_r      <= rev_nxt;
      unf_r      <= unf_nxt;
      ovf_r      <= ovf_nxt;
      pend_r     <= cmd.rd_step;
      stat_vld_r <= cmd.stat_emit;
    end
  end

  // payload side of the result register
  always_ff @(posedge clk) begin
    pend_last_r <= stat.last_idx;
    if (unf_r) begin
      stat_code_r <= dre_pkg::ST_UNDERFLOW;
    end else if (ovf_r) begin
      stat_code_r <= dre_pkg::ST_OVERFLOW;
    end else begin
      stat_code_r <= dre_pkg::ST_EMPTY;
    end
  end

  assign out_strobe       = pend_r || stat_vld_r;
  assign out_data.status  = pend_r ? dre_pkg::ST_ELEMENT : stat_code_r;
  assign out_data.element = pend_r ? dre_pkg::ELEM_W'(rdata) : '0;
  assign out_data.last    = pend_r ? pend_last_r : 1'b1;

endmodule

// ===== hdl/deque_reverse_delete_engine_unit.sv =====
// push, reverse and delete keep busy low; one beat per cycle while not busy
// a status drain (error or empty) gives its result in the cycle after the beat
// an element drain of n items holds busy while reading, one store read per cycle,
// results one per cycle via drain state and registered read, last on the final one
// synchronous active-low reset clears pointers, count and flags; store is not cleared
// the receiver cannot stall: each result is valid for exactly one cycle
`timescale 1ns / 1ps

module deque_reverse_delete_engine_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  dre_pkg::in_t  in_data,
  output logic          out_strobe,
  output dre_pkg::out_t out_data
);

  dre_pkg::cmd_t  cmd;
  dre_pkg::stat_t stat;

  dre_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start && !busy),
    .mode  (in_data.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dre_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .value      (in_data.value),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
